// File: rtl/scc_pkg.sv
// shared constants, request codes and sequencer states for the scc search block
`timescale 1ns / 1ps

package scc_pkg;

    localparam int MAX_NODES = 64;
    localparam int MAX_EDGES = 256;

    localparam int NODE_W  = 6;   // vertex index
    localparam int COUNT_W = 7;   // 0 .. MAX_NODES
    localparam int PTR_W   = 9;   // 0 .. MAX_EDGES
    localparam int EIDX_W  = 8;   // edge slot index
    localparam int RIDX_W  = 7;   // row pointer index, 0 .. MAX_NODES

    localparam logic [1:0] REQ_ROW  = 2'd0;
    localparam logic [1:0] REQ_EDGE = 2'd1;
    localparam logic [1:0] REQ_RUN  = 2'd2;
    localparam logic [1:0] REQ_READ = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_ROOT,
        S_V0,
        S_V1,
        S_V2,
        S_SCAN,
        S_SCAN_T,
        S_SCAN_L,
        S_NOPUSH,
        S_P1,
        S_POP,
        S_RET,
        S_RET1,
        S_RET2
    } state_t;

endpackage

// File: rtl/scc_ram.sv
// generic single write port ram with one registered read port
`timescale 1ns / 1ps

module scc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/strongly_connected_components_top.sv
// tarjan scc search over a graph held in compressed row form, with load and read requests
// row and edge writes give their result in the cycle after acceptance; reads go through S_READ
// before their result is registered; a run is carried out by one sequencer walking the graph
// rams and takes no new request until it is back in idle
// busy is high while a read or run is under way; the receiver cannot stall results
// reset clears control state and sets active_nodes to 64; graph rams hold no reset value
`timescale 1ns / 1ps

module strongly_connected_components_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] req_type,
    input  logic [7:0] slot,
    input  logic [8:0] entry_value,
    input  logic       cfg_we,
    input  logic [6:0] cfg_data,
    output logic       result_valid,
    output logic [5:0] vertex,
    output logic [5:0] component,
    output logic [6:0] component_count,
    output logic       done_res
);

    localparam int NW = scc_pkg::NODE_W;
    localparam int CW = scc_pkg::COUNT_W;
    localparam int PW = scc_pkg::PTR_W;

    scc_pkg::state_t state_reg, state_next;

    logic [CW-1:0] active_nodes_reg;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] root_reg, root_next;
    logic [NW-1:0] j_reg, j_next;
    logic [NW-1:0] top_reg, top_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] ncomp_reg, ncomp_next;
    logic [PW-1:0] px_reg, px_next;
    logic [PW-1:0] end_reg, end_next;
    logic [CW-1:0] low_j_reg, low_j_next;
    logic [CW-1:0] low_k_reg, low_k_next;
    logic          newvis_reg, newvis_next;
    logic [scc_pkg::MAX_NODES-1:0] visited_reg, visited_next;
    logic [scc_pkg::MAX_NODES-1:0] cvalid_reg, cvalid_next;
    logic [CW-1:0] found_count_reg, found_count_next;
    logic [CW-1:0] run_pos_reg, run_pos_next;
    logic [7:0]    read_slot_reg;

    logic          result_valid_reg, result_valid_next;
    logic [NW-1:0] vertex_reg, vertex_next;
    logic [NW-1:0] component_reg, component_next;
    logic          done_res_reg, done_res_next;

    // ram controls
    logic                        rs_we;
    logic [scc_pkg::RIDX_W-1:0]  rs_waddr, rs_raddr;
    logic [PW-1:0]               rs_wdata, rs_q;
    logic                        et_we;
    logic [scc_pkg::EIDX_W-1:0]  et_waddr, et_raddr;
    logic [CW-1:0]               et_wdata, et_q;
    logic                        ll_we;
    logic [NW-1:0]               ll_waddr, ll_raddr;
    logic [CW-1:0]               ll_wdata, ll_q;
    logic                        vi_we;
    logic [NW-1:0]               vi_q;
    logic                        dp_we;
    logic [NW-1:0]               dp_waddr, dp_q;
    logic                        ec_we;
    logic [PW-1:0]               ec_q;
    logic                        ns_we;
    logic [NW-1:0]               ns_waddr, ns_wdata, ns_raddr, ns_q;
    logic                        oo_we;
    logic [NW-1:0]               oo_wdata, oo_q, co_q;

    logic          accept;
    logic [CW-1:0] k_val;
    logic [CW-1:0] min_l;

    assign accept = start && (state_reg == scc_pkg::S_IDLE);
    assign k_val  = et_q;

    scc_ram #(.WIDTH(PW), .DEPTH(scc_pkg::MAX_NODES + 1)) u_row_start (
        .clk(clk), .we(rs_we), .waddr(rs_waddr), .wdata(rs_wdata),
        .raddr(rs_raddr), .rdata(rs_q)
    );
    scc_ram #(.WIDTH(CW), .DEPTH(scc_pkg::MAX_EDGES)) u_edge_target (
        .clk(clk), .we(et_we), .waddr(et_waddr), .wdata(et_wdata),
        .raddr(et_raddr), .rdata(et_q)
    );
    scc_ram #(.WIDTH(CW), .DEPTH(scc_pkg::MAX_NODES)) u_low_link (
        .clk(clk), .we(ll_we), .waddr(ll_waddr), .wdata(ll_wdata),
        .raddr(ll_raddr), .rdata(ll_q)
    );
    scc_ram #(.WIDTH(NW), .DEPTH(scc_pkg::MAX_NODES)) u_visit_index (
        .clk(clk), .we(vi_we), .waddr(j_reg), .wdata(idx_reg[NW-1:0]),
        .raddr(j_reg), .rdata(vi_q)
    );
    scc_ram #(.WIDTH(NW), .DEPTH(scc_pkg::MAX_NODES)) u_dfs_parent (
        .clk(clk), .we(dp_we), .waddr(dp_waddr), .wdata(j_reg),
        .raddr(j_reg), .rdata(dp_q)
    );
    scc_ram #(.WIDTH(PW), .DEPTH(scc_pkg::MAX_NODES)) u_edge_cursor (
        .clk(clk), .we(ec_we), .waddr(j_reg), .wdata(px_reg + PW'(1)),
        .raddr(j_reg), .rdata(ec_q)
    );
    scc_ram #(.WIDTH(NW), .DEPTH(scc_pkg::MAX_NODES)) u_node_stack (
        .clk(clk), .we(ns_we), .waddr(ns_waddr), .wdata(ns_wdata),
        .raddr(ns_raddr), .rdata(ns_q)
    );
    scc_ram #(.WIDTH(NW), .DEPTH(scc_pkg::MAX_NODES)) u_order_out (
        .clk(clk), .we(oo_we), .waddr(pos_reg[NW-1:0]), .wdata(oo_wdata),
        .raddr(slot[NW-1:0]), .rdata(oo_q)
    );
    scc_ram #(.WIDTH(NW), .DEPTH(scc_pkg::MAX_NODES)) u_component_of (
        .clk(clk), .we(oo_we), .waddr(pos_reg[NW-1:0]), .wdata(ncomp_reg[NW-1:0]),
        .raddr(slot[NW-1:0]), .rdata(co_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= scc_pkg::S_IDLE;
            active_nodes_reg <= CW'(scc_pkg::MAX_NODES);
            found_count_reg  <= '0;
            run_pos_reg      <= '0;
            result_valid_reg <= 1'b0;
            visited_reg      <= '0;
            cvalid_reg       <= '0;
            n_reg            <= '0;
            root_reg         <= '0;
            top_reg          <= '0;
            idx_reg          <= '0;
            pos_reg          <= '0;
            ncomp_reg        <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            if (cfg_we)
            begin
                active_nodes_reg <= cfg_data;
            end
            found_count_reg  <= found_count_next;
            run_pos_reg      <= run_pos_next;
            result_valid_reg <= result_valid_next;
            visited_reg      <= visited_next;
            cvalid_reg       <= cvalid_next;
            n_reg            <= n_next;
            root_reg         <= root_next;
            top_reg          <= top_next;
            idx_reg          <= idx_next;
            pos_reg          <= pos_next;
            ncomp_reg        <= ncomp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg         <= j_next;
        px_reg        <= px_next;
        end_reg       <= end_next;
        low_j_reg     <= low_j_next;
        low_k_reg     <= low_k_next;
        newvis_reg    <= newvis_next;
        vertex_reg    <= vertex_next;
        component_reg <= component_next;
        done_res_reg  <= done_res_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        n_next            = n_reg;
        root_next         = root_reg;
        j_next            = j_reg;
        top_next          = top_reg;
        idx_next          = idx_reg;
        pos_next          = pos_reg;
        ncomp_next        = ncomp_reg;
        px_next           = px_reg;
        end_next          = end_reg;
        low_j_next        = low_j_reg;
        low_k_next        = low_k_reg;
        newvis_next       = newvis_reg;
        visited_next      = visited_reg;
        cvalid_next       = cvalid_reg;
        found_count_next  = found_count_reg;
        run_pos_next      = run_pos_reg;
        result_valid_next = 1'b0;
        vertex_next       = '0;
        component_next    = '0;
        done_res_next     = 1'b0;

        rs_we    = 1'b0;
        rs_waddr = slot[scc_pkg::RIDX_W-1:0];
        rs_wdata = (entry_value > PW'(scc_pkg::MAX_EDGES)) ? PW'(scc_pkg::MAX_EDGES)
                                                            : entry_value;
        rs_raddr = {1'b0, j_reg};
        et_we    = 1'b0;
        et_waddr = slot;
        et_wdata = (entry_value > 9'(scc_pkg::MAX_NODES)) ? CW'(scc_pkg::MAX_NODES)
                                                           : entry_value[CW-1:0];
        et_raddr = px_reg[scc_pkg::EIDX_W-1:0];
        ll_we    = 1'b0;
        ll_waddr = j_reg;
        ll_wdata = low_j_reg;
        ll_raddr = j_reg;
        vi_we    = 1'b0;
        dp_we    = 1'b0;
        dp_waddr = k_val[NW-1:0];
        ec_we    = 1'b0;
        ns_we    = 1'b0;
        ns_waddr = top_reg + NW'(1);
        ns_wdata = k_val[NW-1:0];
        ns_raddr = top_reg;
        oo_we    = 1'b0;
        oo_wdata = j_reg;
        min_l    = (ll_q < low_j_reg) ? ll_q : low_j_reg;

        case (state_reg)
            scc_pkg::S_IDLE:
            begin
                if (start)
                begin
                    case (req_type)
                        scc_pkg::REQ_ROW:
                        begin
                            result_valid_next = 1'b1;
                            if (slot <= 8'(scc_pkg::MAX_NODES))
                            begin
                                rs_we         = 1'b1;
                                done_res_next = 1'b1;
                            end
                        end
                        scc_pkg::REQ_EDGE:
                        begin
                            result_valid_next = 1'b1;
                            et_we             = 1'b1;
                            done_res_next     = 1'b1;
                        end
                        scc_pkg::REQ_RUN:
                        begin
                            n_next = (active_nodes_reg > CW'(scc_pkg::MAX_NODES))
                                     ? CW'(scc_pkg::MAX_NODES) : active_nodes_reg;
                            visited_next = '0;
                            cvalid_next  = '0;
                            root_next    = '0;
                            idx_next     = '0;
                            pos_next     = '0;
                            ncomp_next   = '0;
                            state_next   = scc_pkg::S_ROOT;
                        end
                        default:
                        begin
                            state_next = scc_pkg::S_READ;
                        end
                    endcase
                end
            end
            scc_pkg::S_READ:
            begin
                result_valid_next = 1'b1;
                // slot was captured at accept, together with the ram read
                if (read_slot_reg < {1'b0, run_pos_reg})
                begin
                    vertex_next    = oo_q;
                    component_next = co_q;
                    done_res_next  = 1'b1;
                end
                state_next = scc_pkg::S_IDLE;
            end
            scc_pkg::S_ROOT:
            begin
                if (root_reg >= n_reg)
                begin
                    found_count_next  = ncomp_reg;
                    run_pos_next      = pos_reg;
                    result_valid_next = 1'b1;
                    done_res_next     = 1'b1;
                    state_next        = scc_pkg::S_IDLE;
                end
                else if (visited_reg[root_reg[NW-1:0]])
                begin
                    root_next = root_reg + CW'(1);
                end
                else
                begin
                    ns_we      = 1'b1;
                    ns_waddr   = '0;
                    ns_wdata   = root_reg[NW-1:0];
                    top_next   = '0;
                    j_next     = root_reg[NW-1:0];
                    state_next = scc_pkg::S_V0;
                end
            end
            scc_pkg::S_V0:
            begin
                rs_raddr = {1'b0, j_reg} + scc_pkg::RIDX_W'(1);
                if (!visited_reg[j_reg])
                begin
                    visited_next[j_reg] = 1'b1;
                    vi_we       = 1'b1;
                    ll_we       = 1'b1;
                    ll_wdata    = idx_reg;
                    low_j_next  = idx_reg;
                    idx_next    = idx_reg + CW'(1);
                    newvis_next = 1'b1;
                end
                else
                begin
                    newvis_next = 1'b0;
                end
                state_next = scc_pkg::S_V1;
            end
            scc_pkg::S_V1:
            begin
                end_next = rs_q;
                if (!newvis_reg)
                begin
                    low_j_next = ll_q;
                end
                if (cvalid_reg[j_reg])
                begin
                    px_next    = ec_q;
                    state_next = scc_pkg::S_SCAN;
                end
                else
                begin
                    state_next = scc_pkg::S_V2;
                end
            end
            scc_pkg::S_V2:
            begin
                px_next    = rs_q;
                state_next = scc_pkg::S_SCAN;
            end
            scc_pkg::S_SCAN:
            begin
                if ((px_reg >= end_reg) || px_reg[PW-1])
                begin
                    state_next = scc_pkg::S_NOPUSH;
                end
                else
                begin
                    state_next = scc_pkg::S_SCAN_T;
                end
            end
            scc_pkg::S_SCAN_T:
            begin
                ll_raddr = k_val[NW-1:0];
                if (k_val >= n_reg)
                begin
                    px_next    = px_reg + PW'(1);
                    state_next = scc_pkg::S_SCAN;
                end
                else if (visited_reg[k_val[NW-1:0]])
                begin
                    state_next = scc_pkg::S_SCAN_L;
                end
                else
                begin
                    // descend into an unvisited target
                    ec_we              = 1'b1;
                    cvalid_next[j_reg] = 1'b1;
                    ns_we              = 1'b1;
                    top_next           = top_reg + NW'(1);
                    dp_we              = 1'b1;
                    j_next             = k_val[NW-1:0];
                    state_next         = scc_pkg::S_V0;
                end
            end
            scc_pkg::S_SCAN_L:
            begin
                low_j_next = min_l;
                ll_we      = 1'b1;
                ll_wdata   = min_l;
                px_next    = px_reg + PW'(1);
                state_next = scc_pkg::S_SCAN;
            end
            scc_pkg::S_NOPUSH:
            begin
                state_next = scc_pkg::S_P1;
            end
            scc_pkg::S_P1:
            begin
                ns_raddr = top_reg;
                if (low_j_reg == {1'b0, vi_q})
                begin
                    state_next = scc_pkg::S_POP;
                end
                else
                begin
                    state_next = scc_pkg::S_RET;
                end
            end
            scc_pkg::S_POP:
            begin
                ns_raddr = top_reg - NW'(1);
                oo_we    = 1'b1;
                ll_we    = 1'b1;
                ll_wdata = CW'(scc_pkg::MAX_NODES);
                pos_next = pos_reg + CW'(1);
                if ((top_reg != '0) && (ns_q != j_reg))
                begin
                    oo_wdata = ns_q;
                    ll_waddr = ns_q;
                    top_next = top_reg - NW'(1);
                end
                else
                begin
                    // component root closes the component
                    low_j_next = CW'(scc_pkg::MAX_NODES);
                    if (top_reg != '0)
                    begin
                        top_next = top_reg - NW'(1);
                    end
                    ncomp_next = ncomp_reg + CW'(1);
                    state_next = scc_pkg::S_RET;
                end
            end
            scc_pkg::S_RET:
            begin
                if ({1'b0, j_reg} == root_reg)
                begin
                    root_next  = root_reg + CW'(1);
                    state_next = scc_pkg::S_ROOT;
                end
                else
                begin
                    state_next = scc_pkg::S_RET1;
                end
            end
            scc_pkg::S_RET1:
            begin
                j_next     = dp_q;
                low_k_next = low_j_reg;
                ll_raddr   = dp_q;
                state_next = scc_pkg::S_RET2;
            end
            scc_pkg::S_RET2:
            begin
                ll_we      = 1'b1;
                ll_wdata   = (ll_q < low_k_reg) ? ll_q : low_k_reg;
                state_next = scc_pkg::S_V0;
            end
            default:
            begin
                state_next = scc_pkg::S_IDLE;
            end
        endcase
    end

    // read position, registered at accept
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_slot_reg <= slot;
        end
    end

    assign busy            = (state_reg != scc_pkg::S_IDLE);
    assign result_valid    = result_valid_reg;
    assign vertex          = vertex_reg;
    assign component       = component_reg;
    assign component_count = found_count_reg;
    assign done_res        = done_res_reg;

    a_runpos_max: assert property (@(posedge clk) disable iff (!rst_n)
        run_pos_reg <= CW'(scc_pkg::MAX_NODES))
        else $error("emitted positions exceed vertex count");

    a_comp_le_pos: assert property (@(posedge clk) disable iff (!rst_n)
        found_count_reg <= run_pos_reg)
        else $error("more components than emitted vertices");

    a_write_resp: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req_type == scc_pkg::REQ_ROW || req_type == scc_pkg::REQ_EDGE))
        |=> result_valid)
        else $error("write item gave no result");

    a_pos_le_n: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != scc_pkg::S_IDLE && state_reg != scc_pkg::S_READ) |-> pos_reg <= n_reg)
        else $error("run emitted more vertices than searched");

endmodule

// File: dv/strongly_connected_components_top_test.sv
// self-checking testbench for the scc search block: graph loads, runs, reads and active count
`timescale 1ns / 1ps

module strongly_connected_components_top_test;

    typedef struct packed {
        logic [5:0] vertex;
        logic [5:0] component;
        logic [6:0] count;
        logic       done;
    } scc_result_t;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [1:0] req_type;
    logic [7:0] slot;
    logic [8:0] entry_value;
    logic       cfg_we;
    logic [6:0] cfg_data;
    logic       result_valid;
    logic [5:0] vertex;
    logic [5:0] component;
    logic [6:0] component_count;
    logic       done_res;

    strongly_connected_components_top u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .req_type        (req_type),
        .slot            (slot),
        .entry_value     (entry_value),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data),
        .result_valid    (result_valid),
        .vertex          (vertex),
        .component       (component),
        .component_count (component_count),
        .done_res        (done_res)
    );

    // shadow graph and search state
    int          active_cnt;
    int          row_mem [scc_pkg::MAX_NODES+1];
    bit          row_ok [scc_pkg::MAX_NODES+1];
    int          edge_mem [scc_pkg::MAX_EDGES];
    bit          edge_ok [scc_pkg::MAX_EDGES];
    bit          seen [scc_pkg::MAX_NODES];
    int          visit_no [scc_pkg::MAX_NODES];
    int          low_no [scc_pkg::MAX_NODES];
    int          parent_of [scc_pkg::MAX_NODES];
    int          cursor [scc_pkg::MAX_NODES];
    int          dfs_stack [scc_pkg::MAX_NODES];
    int          order_mem [scc_pkg::MAX_NODES];
    int          comp_mem [scc_pkg::MAX_NODES];
    int          comp_total;
    int          order_len;

    scc_result_t pending_results [$];
    int          errors;
    int          items_sent;
    int          runs_sent;
    int          reads_hit;
    int          burst_left;
    bit          no_gaps;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    initial
    begin
        #4000000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic int min_int(int a, int b);
        return a < b ? a : b;
    endfunction

    function automatic void search_components();
        int  n, pos, ncomp, idx, top, j, k, px, e;
        bit  active, pushed;
        n = active_cnt > scc_pkg::MAX_NODES ? scc_pkg::MAX_NODES : active_cnt;
        pos = 0;
        ncomp = 0;
        idx = 0;
        for (int i = 0; i < n; i++)
        begin
            seen[i] = 0;
            visit_no[i] = 0;
            low_no[i] = 0;
            parent_of[i] = scc_pkg::MAX_NODES;
            cursor[i] = row_mem[i];
        end
        for (int i = 0; i < n; i++)
        begin
            if (seen[i])
                continue;
            top = 0;
            j = i;
            active = 1;
            dfs_stack[0] = i;
            while (active)
            begin
                e = row_mem[j+1];
                pushed = 0;
                if (!seen[j])
                begin
                    seen[j] = 1;
                    visit_no[j] = idx;
                    low_no[j] = idx;
                    idx++;
                end
                for (px = cursor[j]; px < e && px < scc_pkg::MAX_EDGES; px++)
                begin
                    k = edge_mem[px];
                    if (k >= n)
                        continue;
                    if (seen[k])
                    begin
                        low_no[j] = min_int(low_no[j], low_no[k]);
                        continue;
                    end
                    cursor[j] = px + 1;
                    top++;
                    dfs_stack[top % scc_pkg::MAX_NODES] = k;
                    parent_of[k] = j;
                    j = k;
                    pushed = 1;
                    break;
                end
                if (!pushed)
                begin
                    if (low_no[j] == visit_no[j])
                    begin
                        while (top > 0 && dfs_stack[top % scc_pkg::MAX_NODES] != j)
                        begin
                            k = dfs_stack[top % scc_pkg::MAX_NODES];
                            top--;
                            if (pos < scc_pkg::MAX_NODES)
                            begin
                                order_mem[pos] = k;
                                comp_mem[pos] = ncomp;
                                pos++;
                            end
                            low_no[k] = scc_pkg::MAX_NODES;
                        end
                        if (pos < scc_pkg::MAX_NODES)
                        begin
                            order_mem[pos] = j;
                            comp_mem[pos] = ncomp;
                            pos++;
                        end
                        low_no[j] = scc_pkg::MAX_NODES;
                        if (top > 0)
                            top--;
                        ncomp++;
                    end
                    k = j;
                    if (parent_of[j] >= n)
                        active = 0;
                    else
                    begin
                        j = parent_of[j];
                        low_no[j] = min_int(low_no[j], low_no[k]);
                    end
                end
            end
        end
        comp_total = ncomp;
        order_len = pos;
    endfunction

    function automatic scc_result_t apply_request(logic [1:0] req, int s, int v);
        scc_result_t r;
        r = '0;
        case (req)
            scc_pkg::REQ_ROW:
                if (s <= scc_pkg::MAX_NODES)
                begin
                    row_mem[s] = v > scc_pkg::MAX_EDGES ? scc_pkg::MAX_EDGES : v;
                    row_ok[s] = 1;
                    r.done = 1'b1;
                end
            scc_pkg::REQ_EDGE:
                if (s < scc_pkg::MAX_EDGES)
                begin
                    edge_mem[s] = v > scc_pkg::MAX_NODES ? scc_pkg::MAX_NODES : v;
                    edge_ok[s] = 1;
                    r.done = 1'b1;
                end
            scc_pkg::REQ_RUN:
            begin
                search_components();
                r.done = 1'b1;
            end
            default:
                if (s < order_len && s < scc_pkg::MAX_NODES)
                begin
                    r.vertex = 6'(order_mem[s]);
                    r.component = 6'(comp_mem[s]);
                    r.done = 1'b1;
                end
        endcase
        r.count = 7'(comp_total);
        return r;
    endfunction

    // a run must only touch graph memory that has been written
    function automatic bit graph_loaded();
        int n;
        n = active_cnt > scc_pkg::MAX_NODES ? scc_pkg::MAX_NODES : active_cnt;
        if (n == 0)
            return 1;
        for (int v = 0; v <= n; v++)
            if (!row_ok[v])
                return 0;
        for (int v = 0; v < n; v++)
            for (int px = row_mem[v]; px < row_mem[v+1] && px < scc_pkg::MAX_EDGES; px++)
                if (!edge_ok[px])
                    return 0;
        return 1;
    endfunction

    task automatic send_item(logic [1:0] req, int s, int v);
        if (!no_gaps && burst_left == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0)
            burst_left--;
        start <= 1'b1;
        req_type <= req;
        slot <= s[7:0];
        entry_value <= v[8:0];
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(apply_request(req, s, v));
        items_sent++;
        if (req == scc_pkg::REQ_RUN)
            runs_sent++;
        if (req == scc_pkg::REQ_READ && s < order_len)
            reads_hit++;
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_active(int v);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_data <= v[6:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        active_cnt = v;
    endtask

    always @(posedge clk)
    begin
        scc_result_t want;
        if (rst_n && result_valid)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no item outstanding");
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (vertex !== want.vertex)
                begin
                    $error("vertex: expected %0d, got %0d", want.vertex, vertex);
                    errors++;
                end
                if (component !== want.component)
                begin
                    $error("component: expected %0d, got %0d", want.component, component);
                    errors++;
                end
                if (component_count !== want.count)
                begin
                    $error("component_count: expected %0d, got %0d",
                           want.count, component_count);
                    errors++;
                end
                if (done_res !== want.done)
                begin
                    $error("done_res: expected %0d, got %0d", want.done, done_res);
                    errors++;
                end
            end
        end
    end

    // loads a random graph over n vertices, runs it and reads back the order
    task automatic graph_round(int n, int max_deg);
        int ptr [scc_pkg::MAX_NODES+1];
        int top_ptr;
        int cfg;
        cfg = n;
        if (n == scc_pkg::MAX_NODES && $urandom_range(0, 1))
            cfg = $urandom_range(65, 127);
        set_active(cfg);
        ptr[0] = $urandom_range(0, 3);
        top_ptr = ptr[0];
        for (int v = 1; v <= n; v++)
        begin
            ptr[v] = ptr[v-1] + $urandom_range(0, max_deg);
            // now and then a row that runs backwards
            if ($urandom_range(0, 15) == 0 && ptr[v] > 1)
                ptr[v] = ptr[v] - $urandom_range(1, 2);
            if (ptr[v] > scc_pkg::MAX_EDGES)
                ptr[v] = scc_pkg::MAX_EDGES;
            if (ptr[v] > top_ptr)
                top_ptr = ptr[v];
        end
        for (int v = 0; v <= n; v++)
            send_item(scc_pkg::REQ_ROW, v, ptr[v]);
        for (int px = 0; px < top_ptr; px++)
        begin
            int t;
            case ($urandom_range(0, 19))
                0:       t = $urandom_range(n, 511);
                1:       t = $urandom_range(0, 63);
                default: t = $urandom_range(0, n - 1);
            endcase
            send_item(scc_pkg::REQ_EDGE, px, t);
        end
        send_item(scc_pkg::REQ_RUN, $urandom_range(0, 255), $urandom_range(0, 511));
        for (int p = 0; p < n; p++)
            send_item(scc_pkg::REQ_READ, p, $urandom_range(0, 511));
        send_item(scc_pkg::REQ_READ, $urandom_range(n, 255), 0);
    endtask

    task automatic test_before_any_run();
        send_item(scc_pkg::REQ_READ, 0, 0);
        send_item(scc_pkg::REQ_READ, 255, 511);
        send_item(scc_pkg::REQ_ROW, 65, 3);
        send_item(scc_pkg::REQ_ROW, 255, 511);
        send_item(scc_pkg::REQ_EDGE, 255, 511);
        send_item(scc_pkg::REQ_EDGE, 128, 256);
        set_active(0);
        send_item(scc_pkg::REQ_RUN, 0, 0);
        send_item(scc_pkg::REQ_READ, 0, 0);
    endtask

    task automatic test_known_graph();
        int rows [5] = '{0, 2, 4, 6, 8};
        int dest [8] = '{1, 0, 0, 2, 3, 2, 3, 5};
        set_active(4);
        for (int v = 0; v < 5; v++)
            send_item(scc_pkg::REQ_ROW, v, rows[v]);
        for (int e = 0; e < 8; e++)
            send_item(scc_pkg::REQ_EDGE, e, dest[e]);
        send_item(scc_pkg::REQ_RUN, 0, 0);
        for (int p = 0; p < 5; p++)
            send_item(scc_pkg::REQ_READ, p, 0);
    endtask

    task automatic test_full_graph();
        set_active(127);
        for (int v = 0; v < scc_pkg::MAX_NODES; v++)
            send_item(scc_pkg::REQ_ROW, v, v * 4);
        // top row pointer saturates
        send_item(scc_pkg::REQ_ROW, scc_pkg::MAX_NODES, 511);
        for (int e = 0; e < scc_pkg::MAX_EDGES; e++)
            send_item(scc_pkg::REQ_EDGE, e, (e % 7 == 0) ? 511 : $urandom_range(0, 63));
        send_item(scc_pkg::REQ_RUN, 0, 0);
        for (int p = 0; p < scc_pkg::MAX_NODES; p += 3)
            send_item(scc_pkg::REQ_READ, p, 0);
        send_item(scc_pkg::REQ_READ, 63, 0);
        set_active(1);
        send_item(scc_pkg::REQ_RUN, 0, 0);
        send_item(scc_pkg::REQ_READ, 0, 0);
        send_item(scc_pkg::REQ_READ, 1, 0);
    endtask

    task automatic test_random_graphs();
        int goal;
        goal = items_sent + 300;
        while (items_sent < goal)
        begin
            no_gaps = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 11) == 0)
                graph_round(scc_pkg::MAX_NODES, 3);
            else
                graph_round($urandom_range(1, 10), $urandom_range(1, 4));
        end
        no_gaps = 0;
    endtask

    task automatic test_mixed_noise();
        for (int i = 0; i < 60; i++)
        begin
            logic [1:0] req;
            req = 2'($urandom_range(0, 3));
            if (req == scc_pkg::REQ_RUN && !graph_loaded())
                req = scc_pkg::REQ_READ;
            send_item(req, $urandom_range(0, 255), $urandom_range(0, 511));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        req_type = scc_pkg::REQ_ROW;
        slot = '0;
        entry_value = '0;
        cfg_we = 1'b0;
        cfg_data = '0;
        errors = 0;
        items_sent = 0;
        runs_sent = 0;
        reads_hit = 0;
        burst_left = 0;
        no_gaps = 0;
        active_cnt = scc_pkg::MAX_NODES;
        comp_total = 0;
        order_len = 0;
        for (int i = 0; i <= scc_pkg::MAX_NODES; i++)
            row_ok[i] = 0;
        for (int i = 0; i < scc_pkg::MAX_EDGES; i++)
            edge_ok[i] = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_before_any_run();
        test_known_graph();
        test_full_graph();
        test_random_graphs();
        test_mixed_noise();

        wait_idle();
        repeat (20) @(posedge clk);
        $display("covered %0d items: %0d search runs, %0d reads inside the found order",
                 items_sent, runs_sent, reads_hit);
        $display("active counts 0, 1, 64 and above 64, saturated pointers and targets");
        if (errors == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
